// File: src/gpio_bank_with_atomic_aliases_macros.svh
// Assertion macros for the GPIO bank.
`ifndef GPIO_BANK_WITH_ATOMIC_ALIASES_MACROS_SVH
`define GPIO_BANK_WITH_ATOMIC_ALIASES_MACROS_SVH
`ifndef SYNTHESIS
`define GBA_ASSERT_CLK(label, clk_sig, rstn_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) else $error(msg);
`define GBA_ASSERT_NORST(label, clk_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) prop) else $error(msg);
`else
`define GBA_ASSERT_CLK(label, clk_sig, rstn_sig, prop, msg)
`define GBA_ASSERT_NORST(label, clk_sig, prop, msg)
`endif
`endif

// File: src/gba_pkg.sv
package gba_pkg;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [1:0] SPACE_GPIO = 2'd0;
    localparam logic [1:0] SPACE_RIO  = 2'd1;
    localparam logic [1:0] SPACE_PADS = 2'd2;

    localparam logic [1:0] ALIAS_PLAIN = 2'd0;
    localparam logic [1:0] ALIAS_XOR   = 2'd1;
    localparam logic [1:0] ALIAS_SET   = 2'd2;
    localparam logic [1:0] ALIAS_CLR   = 2'd3;

    localparam logic [1:0] OVR_NONE = 2'd0;
    localparam logic [1:0] OVR_INV  = 2'd1;
    localparam logic [1:0] OVR_LOW  = 2'd2;
    localparam logic [1:0] OVR_HIGH = 2'd3;

    localparam logic [11:0] INTE_OFF   = 12'h11c;
    localparam logic [11:0] INTS_OFF   = 12'h124;
    localparam logic [11:0] RIO_OUT    = 12'h000;
    localparam logic [11:0] RIO_OE     = 12'h004;
    localparam logic [11:0] RIO_IN     = 12'h008;

    localparam logic [31:0] CTRL_KEEP  = 32'h00f3f01f;
    localparam logic [31:0] CTRL_RESET = 32'h0000001f;
    localparam int          CTRL_IRQRESET_BIT = 28;
    localparam logic [4:0]  FSEL_RIO   = 5'd5;
    localparam int          PAD_OUT_DIS_BIT = 7;

    typedef struct packed {
        logic lvl;
        logic po;
        logic oe;
        logic ev;
    } lane_t;

    function automatic logic [31:0] apply_alias(input logic [31:0] old_v,
                                                input logic [31:0] w,
                                                input logic [1:0] kind);
        logic [31:0] r;
        case (kind)
            ALIAS_XOR: r = old_v ^ w;
            ALIAS_SET: r = old_v | w;
            ALIAS_CLR: r = old_v & ~w;
            default:   r = w;
        endcase
        return r;
    endfunction

    function automatic logic override_bit(input logic v, input logic [1:0] ov);
        logic r;
        case (ov)
            OVR_NONE: r = v;
            OVR_INV:  r = ~v;
            OVR_LOW:  r = 1'b0;
            default:  r = 1'b1;
        endcase
        return r;
    endfunction

endpackage

// File: src/gpio_bank_with_atomic_aliases.sv
// GPIO bank with plain, XOR, set and clear access aliases.
// Input channel: in_valid / in_stall carry one transaction per cycle: a bus
// read, a bus write (alias_req picks the write kind) or a tick that samples
// pin_levels and latches rising and falling edges.
// Output channel: out_valid / out_stall carry one result per input
// transaction: rdata (zero except on reads) plus pin_out, pin_oe and
// irq_line as they stand after that transaction has taken effect.
// Timing: the result appears in the cycle after the input is accepted; the
// state update is shallow bitwise logic in front of one output register.
// Throughput: one transaction per cycle while the receiver does not stall.
// Stall: while the output register holds a result the receiver has stalled,
// in_stall is raised and the input side waits; the result holds unchanged.
// Reset: rst_n clears the bank state asynchronously: function select 31 on every
// pin, everything else zero; no result is pending after reset.
`include "gpio_bank_with_atomic_aliases_macros.svh"
module gpio_bank_with_atomic_aliases
    import gba_pkg::*;
#(
    parameter int PINS = 28
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [1:0]  space,
    input  logic [1:0]  alias_req,
    input  logic [11:0] offset,
    input  logic [31:0] wdata,
    input  logic [31:0] pin_levels,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] rdata,
    output logic [31:0] pin_out,
    output logic [31:0] pin_oe,
    output logic        irq_line
);
    localparam int IDXW = (PINS > 1) ? $clog2(PINS) : 1;
    localparam logic [31:0] PMASK = 32'((64'd1 << PINS) - 64'd1);
    localparam logic [11:0] GPIO_END = 12'(8 * PINS);
    localparam logic [11:0] PAD_END  = 12'(4 + 4 * PINS);

    // Bank state
    logic [31:0] ctrl_reg  [PINS];
    logic [31:0] ctrl_next [PINS];
    logic [1:0]  latch_reg [PINS];
    logic [1:0]  latch_next[PINS];
    logic [7:0]  pad_reg   [PINS];
    logic [7:0]  pad_next  [PINS];
    logic [31:0] rio_o_reg, rio_o_next;
    logic [31:0] rio_oe_reg, rio_oe_next;
    logic [31:0] inte_reg, inte_next;
    logic [31:0] last_reg, last_next;

    // Result register
    logic        out_valid_reg;
    logic [31:0] rdata_reg, rdata_next;
    logic [31:0] pin_out_reg, pin_oe_reg;
    logic        irq_reg;

    logic        accept;
    logic [11:0] off;
    logic [11:0] pad_off;
    logic        gpio_hit, pad_hit;
    logic [IDXW-1:0] gidx, pidx;
    logic [31:0] levels_m;

    lane_t       cur_lane [PINS];
    lane_t       nxt_lane [PINS];
    logic [31:0] cur_lvl, cur_ev, nxt_po, nxt_oe, nxt_ev;
    logic [31:0] ctrl_alias, cur_ints;
    logic [31:0] pad_alias;
    logic        irq_now;
    logic [31:0] hi_drive;

    // Accept a new transaction whenever the result register is free or drains.
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    assign off      = {offset[11:2], 2'b00};
    assign pad_off  = off - 12'd4;
    assign gpio_hit = (off < GPIO_END);
    assign pad_hit  = (off >= 12'd4) && (off < PAD_END);
    assign gidx     = off[3 +: IDXW];
    assign pidx     = pad_off[2 +: IDXW];
    assign levels_m = pin_levels & PMASK;

    genvar g;
    generate
        for (g = 0; g < PINS; g++)
        begin : g_lane
            gba_lane u_cur (
                .ctrl    (ctrl_reg[g]),
                .latch   (latch_reg[g]),
                .pad     (pad_reg[g]),
                .rio_o   (rio_o_reg[g]),
                .rio_oe  (rio_oe_reg[g]),
                .lvl_raw (last_reg[g]),
                .lane    (cur_lane[g])
            );
            gba_lane u_nxt (
                .ctrl    (ctrl_next[g]),
                .latch   (latch_next[g]),
                .pad     (pad_next[g]),
                .rio_o   (rio_o_next[g]),
                .rio_oe  (rio_oe_next[g]),
                .lvl_raw (last_next[g]),
                .lane    (nxt_lane[g])
            );
        end
    endgenerate

    // Collect per-pin results into words; bits from PINS upward read as zero.
    always_comb
    begin
        cur_lvl = '0;
        cur_ev  = '0;
        nxt_po  = '0;
        nxt_oe  = '0;
        nxt_ev  = '0;
        for (int p = 0; p < PINS; p++)
        begin
            cur_lvl[p] = cur_lane[p].lvl;
            cur_ev[p]  = cur_lane[p].ev;
            nxt_po[p]  = nxt_lane[p].po;
            nxt_oe[p]  = nxt_lane[p].oe;
            nxt_ev[p]  = nxt_lane[p].ev;
        end
        cur_ints = cur_ev & inte_reg & PMASK;
    end

    // Read path, from the state before this transaction
    always_comb
    begin
        rdata_next = '0;
        if (cmd == CMD_READ)
        begin
            case (space)
                SPACE_GPIO:
                begin
                    if (gpio_hit)
                    begin
                        if (off[2])
                            rdata_next = ctrl_reg[gidx];
                        else
                            rdata_next = {8'd0, cur_lvl[gidx], ~cur_lvl[gidx],
                                          latch_reg[gidx], 20'd0};
                    end
                    else if (off == INTE_OFF)
                        rdata_next = inte_reg;
                    else if (off == INTS_OFF)
                        rdata_next = cur_ints;
                end
                SPACE_RIO:
                begin
                    if (off == RIO_OUT)
                        rdata_next = rio_o_reg;
                    else if (off == RIO_OE)
                        rdata_next = rio_oe_reg;
                    else if (off == RIO_IN)
                        rdata_next = cur_lvl;
                end
                SPACE_PADS:
                begin
                    if (pad_hit)
                        rdata_next = {24'd0, pad_reg[pidx]};
                end
                default: rdata_next = '0;
            endcase
        end
    end

    assign ctrl_alias = apply_alias(ctrl_reg[gidx], wdata, alias_req);
    assign pad_alias  = apply_alias({24'd0, pad_reg[pidx]}, wdata, alias_req);

    // Next state for writes and ticks
    always_comb
    begin
        ctrl_next   = ctrl_reg;
        latch_next  = latch_reg;
        pad_next    = pad_reg;
        rio_o_next  = rio_o_reg;
        rio_oe_next = rio_oe_reg;
        inte_next   = inte_reg;
        last_next   = last_reg;
        if (accept)
        begin
            case (cmd)
                CMD_WRITE:
                begin
                    case (space)
                        SPACE_GPIO:
                        begin
                            if (gpio_hit)
                            begin
                                if (off[2])
                                begin
                                    ctrl_next[gidx] = ctrl_alias & CTRL_KEEP;
                                    if (ctrl_alias[CTRL_IRQRESET_BIT])
                                        latch_next[gidx] = 2'b00;
                                end
                            end
                            else if (off == INTE_OFF)
                                inte_next = apply_alias(inte_reg, wdata, alias_req) & PMASK;
                        end
                        SPACE_RIO:
                        begin
                            if (off == RIO_OUT)
                                rio_o_next = apply_alias(rio_o_reg, wdata, alias_req) & PMASK;
                            else if (off == RIO_OE)
                                rio_oe_next = apply_alias(rio_oe_reg, wdata, alias_req)
                                              & PMASK;
                        end
                        SPACE_PADS:
                        begin
                            if (pad_hit)
                                pad_next[pidx] = pad_alias[7:0];
                        end
                        default: ;
                    endcase
                end
                CMD_TICK:
                begin
                    // Compare old and new levels, both through the current input override.
                    for (int p = 0; p < PINS; p++)
                    begin
                        if (!cur_lvl[p] && override_bit(levels_m[p], ctrl_reg[p][17:16]))
                            latch_next[p][1] = 1'b1;
                        if (cur_lvl[p] && !override_bit(levels_m[p], ctrl_reg[p][17:16]))
                            latch_next[p][0] = 1'b1;
                    end
                    last_next = levels_m;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PINS; p++)
            begin
                ctrl_reg[p]  <= CTRL_RESET;
                latch_reg[p] <= '0;
                pad_reg[p]   <= '0;
            end
            rio_o_reg     <= '0;
            rio_oe_reg    <= '0;
            inte_reg      <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg   <= ctrl_next;
            latch_reg  <= latch_next;
            pad_reg    <= pad_next;
            rio_o_reg  <= rio_o_next;
            rio_oe_reg <= rio_oe_next;
            inte_reg   <= inte_next;
            last_reg   <= last_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign irq_now  = |(nxt_ev & inte_next & PMASK);
    assign hi_drive = (pin_oe_reg | pin_out_reg) & ~PMASK;

    // Result payload: load on accept, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg   <= rdata_next;
            pin_out_reg <= nxt_po;
            pin_oe_reg  <= nxt_oe;
            irq_reg     <= irq_now;
        end
    end

    assign out_valid = out_valid_reg;
    assign rdata     = rdata_reg;
    assign pin_out   = pin_out_reg;
    assign pin_oe    = pin_oe_reg;
    assign irq_line  = irq_reg;

    `GBA_ASSERT_CLK(a_out_src, clk, rst_n, $rose(out_valid_reg) |-> $past(accept), "orphan result")
    `GBA_ASSERT_CLK(a_irq_inte, clk, rst_n, irq_now |-> |inte_next, "irq with no enable")
    `GBA_ASSERT_CLK(a_high_quiet, clk, rst_n, out_valid_reg |-> (hi_drive == '0), "high pin drive")
    `GBA_ASSERT_NORST(a_reset_empty, clk, !rst_n |=> !out_valid_reg, "result pending after reset")

endmodule

// File: src/gba_lane.sv
module gba_lane
    import gba_pkg::*;
(
    input  logic [31:0] ctrl,
    input  logic [1:0]  latch,
    input  logic [7:0]  pad,
    input  logic        rio_o,
    input  logic        rio_oe,
    input  logic        lvl_raw,
    output lane_t       lane
);
    logic is_rio;

    always_comb
    begin
        is_rio   = (ctrl[4:0] == FSEL_RIO);
        lane.lvl = override_bit(lvl_raw, ctrl[17:16]);
        lane.po  = override_bit(is_rio & rio_o, ctrl[13:12]);
        lane.oe  = override_bit(is_rio & rio_oe, ctrl[15:14]) & ~pad[PAD_OUT_DIS_BIT];
        // drop any event whose enable is clear
        lane.ev  = (latch[0] & ctrl[20]) | (latch[1] & ctrl[21]) |
                   (~lane.lvl & ctrl[22]) | (lane.lvl & ctrl[23]);
    end
endmodule

// File: bench/gpio_bank_with_atomic_aliases_tb.sv
module gpio_bank_with_atomic_aliases_tb;
    import gba_pkg::*;

    localparam int NPINS = 28;
    localparam logic [31:0] PIN_MASK = 32'h0fff_ffff;

    typedef struct packed {
        logic [31:0] rdata;
        logic [31:0] pin_out;
        logic [31:0] pin_oe;
        logic        irq_line;
    } gpio_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  cmd;
    logic [1:0]  space;
    logic [1:0]  alias_req;
    logic [11:0] offset;
    logic [31:0] wdata;
    logic [31:0] pin_levels;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] rdata;
    logic [31:0] pin_out;
    logic [31:0] pin_oe;
    logic        irq_line;

    // Shadow copy of the bank state, advanced once per accepted transaction
    logic [31:0] shadow_ctrl [NPINS];
    logic [1:0]  shadow_edges [NPINS];
    logic [7:0]  shadow_pads [NPINS];
    logic [31:0] shadow_rio_out;
    logic [31:0] shadow_rio_oe;
    logic [31:0] shadow_inte;
    logic [31:0] shadow_levels;

    gpio_result_t pending_results [$];
    int mismatches;
    bit idle_on;
    int hold_req;

    gpio_bank_with_atomic_aliases DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .space(space), .alias_req(alias_req), .offset(offset),
        .wdata(wdata), .pin_levels(pin_levels),
        .out_valid(out_valid), .out_stall(out_stall),
        .rdata(rdata), .pin_out(pin_out), .pin_oe(pin_oe), .irq_line(irq_line)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on run time; a healthy run ends far earlier
    initial
    begin
        #3000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [31:0] merge_word(logic [31:0] old_v, logic [31:0] w,
                                               logic [1:0] kind);
        case (kind)
            ALIAS_XOR: return old_v ^ w;
            ALIAS_SET: return old_v | w;
            ALIAS_CLR: return old_v & ~w;
            default:   return w;
        endcase
    endfunction

    function automatic logic force_bit(logic v, logic [1:0] sel);
        case (sel)
            OVR_NONE: return v;
            OVR_INV:  return ~v;
            OVR_LOW:  return 1'b0;
            default:  return 1'b1;
        endcase
    endfunction

    function automatic logic pin_level(int p, logic [31:0] lv);
        return force_bit(lv[p], shadow_ctrl[p][17:16]);
    endfunction

    // Enabled pin events masked by the interrupt-enable word
    function automatic logic [31:0] irq_status();
        logic [31:0] w;
        logic lvl;
        logic [31:0] c;
        w = '0;
        for (int p = 0; p < NPINS; p++)
        begin
            c = shadow_ctrl[p];
            lvl = pin_level(p, shadow_levels);
            w[p] = (shadow_edges[p][0] & c[20]) | (shadow_edges[p][1] & c[21]) |
                   (~lvl & c[22]) | (lvl & c[23]);
        end
        return w & shadow_inte & PIN_MASK;
    endfunction

    function automatic logic [31:0] read_reg(logic [1:0] sp, logic [11:0] off);
        logic [31:0] w;
        int p;
        w = '0;
        if (sp == SPACE_GPIO)
        begin
            if (off < 8 * NPINS)
            begin
                p = off >> 3;
                if (off[2])
                    w = shadow_ctrl[p];
                else
                begin
                    w[21:20] = shadow_edges[p];
                    if (pin_level(p, shadow_levels))
                        w[23] = 1'b1;
                    else
                        w[22] = 1'b1;
                end
            end
            else if (off == INTE_OFF)
                w = shadow_inte;
            else if (off == INTS_OFF)
                w = irq_status();
        end
        else if (sp == SPACE_RIO)
        begin
            if (off == RIO_OUT)
                w = shadow_rio_out;
            else if (off == RIO_OE)
                w = shadow_rio_oe;
            else if (off == RIO_IN)
                for (int q = 0; q < NPINS; q++)
                    w[q] = pin_level(q, shadow_levels);
        end
        else if (sp == SPACE_PADS && off >= 4 && off < 4 + 4 * NPINS)
            w = {24'd0, shadow_pads[(off - 4) >> 2]};
        return w;
    endfunction

    task automatic write_reg(logic [1:0] sp, logic [11:0] off, logic [1:0] kind,
                             logic [31:0] w);
        logic [31:0] v;
        int p;
        if (sp == SPACE_GPIO)
        begin
            if (off < 8 * NPINS)
            begin
                p = off >> 3;
                if (off[2])
                begin
                    v = merge_word(shadow_ctrl[p], w, kind);
                    if (v[CTRL_IRQRESET_BIT])
                        shadow_edges[p] = 2'b00;
                    shadow_ctrl[p] = v & CTRL_KEEP;
                end
            end
            else if (off == INTE_OFF)
                shadow_inte = merge_word(shadow_inte, w, kind) & PIN_MASK;
        end
        else if (sp == SPACE_RIO)
        begin
            if (off == RIO_OUT)
                shadow_rio_out = merge_word(shadow_rio_out, w, kind) & PIN_MASK;
            else if (off == RIO_OE)
                shadow_rio_oe = merge_word(shadow_rio_oe, w, kind) & PIN_MASK;
        end
        else if (sp == SPACE_PADS && off >= 4 && off < 4 + 4 * NPINS)
        begin
            p = (off - 4) >> 2;
            v = merge_word({24'd0, shadow_pads[p]}, w, kind);
            shadow_pads[p] = v[7:0];
        end
    endtask

    task automatic sample_pins(logic [31:0] lv);
        logic prev;
        logic cur;
        lv = lv & PIN_MASK;
        for (int p = 0; p < NPINS; p++)
        begin
            prev = pin_level(p, shadow_levels);
            cur = pin_level(p, lv);
            if (!prev && cur)
                shadow_edges[p][1] = 1'b1;
            if (prev && !cur)
                shadow_edges[p][0] = 1'b1;
        end
        shadow_levels = lv;
    endtask

    // Advance the shadow state by one transaction and queue what the bank must show
    task automatic predict_gpio(logic [1:0] c, logic [1:0] sp, logic [1:0] kind,
                                logic [11:0] off_in, logic [31:0] w, logic [31:0] lv);
        gpio_result_t r;
        logic [11:0] off;
        logic po;
        logic oe;
        logic rio_sel;
        off = off_in & 12'hffc;
        r = '0;
        if (c == CMD_READ)
            r.rdata = read_reg(sp, off);
        else if (c == CMD_WRITE)
            write_reg(sp, off, kind, w);
        else if (c == CMD_TICK)
            sample_pins(lv);
        for (int p = 0; p < NPINS; p++)
        begin
            rio_sel = shadow_ctrl[p][4:0] == FSEL_RIO;
            po = force_bit(rio_sel & shadow_rio_out[p], shadow_ctrl[p][13:12]);
            oe = force_bit(rio_sel & shadow_rio_oe[p], shadow_ctrl[p][15:14]);
            if (shadow_pads[p][PAD_OUT_DIS_BIT])
                oe = 1'b0;
            r.pin_out[p] = po;
            r.pin_oe[p] = oe;
        end
        r.irq_line = irq_status() != 0;
        pending_results.push_back(r);
    endtask

    // Offer one transaction, hold it until accepted, then predict it
    task automatic send_txn(logic [1:0] c, logic [1:0] sp, logic [1:0] kind,
                            logic [11:0] off, logic [31:0] w, logic [31:0] lv);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 7);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        cmd = c;
        space = sp;
        alias_req = kind;
        offset = off;
        wdata = w;
        pin_levels = lv;
        do
            @(posedge clk);
        while (in_stall);
        predict_gpio(c, sp, kind, off, w, lv);
    endtask

    // Receiver: random stall bursts, plus a long hold-off when requested
    initial
    begin
        int burst;
        int hold;
        out_stall = 1'b0;
        burst = 0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold = hold_req;
                hold_req = 0;
            end
            if (hold > 0)
            begin
                out_stall = 1'b1;
                hold--;
            end
            else if (burst > 0)
            begin
                out_stall = 1'b1;
                burst--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall = 1'b1;
                burst = $urandom_range(0, 6);
            end
            else
                out_stall = 1'b0;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        gpio_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result rdata=%h out=%h oe=%h irq=%b",
                             rdata, pin_out, pin_oe, irq_line);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (exp_r.rdata !== rdata || exp_r.pin_out !== pin_out ||
                    exp_r.pin_oe !== pin_oe || exp_r.irq_line !== irq_line)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp rdata=%h out=%h oe=%h irq=%b / got %h %h %h %b",
                                 exp_r.rdata, exp_r.pin_out, exp_r.pin_oe, exp_r.irq_line,
                                 rdata, pin_out, pin_oe, irq_line);
                end
            end
        end
    end

    function automatic logic [11:0] pick_offset(logic [1:0] sp);
        int p;
        p = $urandom_range(0, NPINS - 1);
        if ($urandom_range(0, 9) == 0)
            return 12'($urandom);
        case (sp)
            SPACE_GPIO:
                case ($urandom_range(0, 5))
                    0: return 12'(8 * p);
                    1: return INTE_OFF;
                    2: return INTS_OFF;
                    default: return 12'(8 * p + 4);
                endcase
            SPACE_RIO: return 12'(4 * $urandom_range(0, 2));
            default: return 12'(4 + 4 * p);
        endcase
    endfunction

    function automatic logic [31:0] pick_wdata(logic [1:0] sp);
        logic [31:0] w;
        w = $urandom;
        // Bias control words toward the RIO function so outputs move
        if (sp == SPACE_GPIO && $urandom_range(0, 2) != 0)
            w[4:0] = FSEL_RIO;
        if ($urandom_range(0, 3) != 0)
            w[CTRL_IRQRESET_BIT] = 1'b0;
        return w;
    endfunction

    task automatic rand_txn();
        logic [1:0] c;
        logic [1:0] sp;
        c = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        sp = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        send_txn(c, sp, 2'($urandom), pick_offset(sp), pick_wdata(sp), $urandom);
    endtask

    // Reset values, unmapped offsets, space 3 and a no-op command
    task automatic test_reset_view();
        send_txn(CMD_READ, SPACE_GPIO, ALIAS_PLAIN, 12'h004, '0, '0);
        send_txn(CMD_READ, SPACE_GPIO, ALIAS_XOR, 12'h000, '0, '0);
        send_txn(CMD_READ, SPACE_GPIO, ALIAS_PLAIN, INTS_OFF, '0, '0);
        send_txn(CMD_READ, SPACE_RIO, ALIAS_PLAIN, RIO_IN, '0, '0);
        send_txn(CMD_READ, SPACE_GPIO, ALIAS_PLAIN, 12'hfff, '0, '1);
        send_txn(CMD_WRITE, 2'd3, ALIAS_PLAIN, 12'h004, '1, '0);
        send_txn(2'd3, SPACE_PADS, ALIAS_PLAIN, 12'h004, '1, '1);
    endtask

    // Every alias kind on a plain register, writes to read-only words
    task automatic test_alias_kinds();
        send_txn(CMD_WRITE, SPACE_GPIO, ALIAS_PLAIN, INTE_OFF, 32'hffff_ffff, '0);
        send_txn(CMD_WRITE, SPACE_GPIO, ALIAS_XOR, INTE_OFF, 32'h00ff_00ff, '0);
        send_txn(CMD_WRITE, SPACE_GPIO, ALIAS_CLR, INTE_OFF, 32'h0000_000f, '0);
        send_txn(CMD_WRITE, SPACE_GPIO, ALIAS_SET, INTE_OFF, 32'h0000_0003, '0);
        send_txn(CMD_READ, SPACE_GPIO, ALIAS_PLAIN, INTE_OFF, '0, '0);
        send_txn(CMD_WRITE, SPACE_GPIO, ALIAS_PLAIN, INTS_OFF, '1, '0);
        send_txn(CMD_WRITE, SPACE_RIO, ALIAS_PLAIN, RIO_IN, '1, '0);
    endtask

    // RIO outputs through function select, overrides and pad output disable
    task automatic test_outputs();
        send_txn(CMD_WRITE, SPACE_RIO, ALIAS_PLAIN, RIO_OUT, 32'haaaa_aaaa, '0);
        send_txn(CMD_WRITE, SPACE_RIO, ALIAS_SET, RIO_OE, '1, '0);
        send_txn(CMD_WRITE, SPACE_GPIO, ALIAS_PLAIN, 12'h00c, 32'h0000_0005, '0);
        send_txn(CMD_WRITE, SPACE_GPIO, ALIAS_PLAIN, 12'h014, 32'h0000_7005, '0);
        send_txn(CMD_WRITE, SPACE_PADS, ALIAS_PLAIN, 12'h008, 32'h0000_0080, '0);
        send_txn(CMD_WRITE, SPACE_GPIO, ALIAS_PLAIN, 12'h0dc, 32'hffff_ffff, '0);
    endtask

    // Edge latching, interrupt, and edge clearing through the set alias
    task automatic test_edges_irq();
        send_txn(CMD_WRITE, SPACE_GPIO, ALIAS_PLAIN, 12'h004, 32'h0030_0000, '0);
        send_txn(CMD_TICK, SPACE_GPIO, ALIAS_PLAIN, '0, '0, 32'hffff_ffff);
        send_txn(CMD_TICK, SPACE_GPIO, ALIAS_PLAIN, '0, '0, 32'h0000_0000);
        send_txn(CMD_READ, SPACE_GPIO, ALIAS_SET, 12'h000, '0, '0);
        send_txn(CMD_WRITE, SPACE_GPIO, ALIAS_CLR, 12'h004, 32'h1000_0000, '0);
        send_txn(CMD_WRITE, SPACE_GPIO, ALIAS_SET, 12'h004, 32'h1001_0000, '0);
        send_txn(CMD_TICK, SPACE_GPIO, ALIAS_PLAIN, '0, '0, 32'h0000_0000);
        send_txn(CMD_READ, SPACE_GPIO, ALIAS_PLAIN, INTS_OFF, '0, '0);
    endtask

    // Hold the receiver off long enough that the bank backs up its input
    task automatic test_backpressure();
        hold_req = 200;
        repeat (30) rand_txn();
    endtask

    task automatic test_random(int n);
        repeat (n) rand_txn();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_READ;
        space = SPACE_GPIO;
        alias_req = ALIAS_PLAIN;
        offset = '0;
        wdata = '0;
        pin_levels = '0;
        mismatches = 0;
        idle_on = 1'b1;
        hold_req = 0;
        for (int p = 0; p < NPINS; p++)
        begin
            shadow_ctrl[p] = CTRL_RESET;
            shadow_edges[p] = 2'b00;
            shadow_pads[p] = 8'h00;
        end
        shadow_rio_out = '0;
        shadow_rio_oe = '0;
        shadow_inte = '0;
        shadow_levels = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_reset_view();
        test_alias_kinds();
        test_outputs();
        test_edges_irq();
        test_backpressure();
        test_random(1400);
        // Drop idling for the final stretch
        idle_on = 1'b0;
        test_random(300);

        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
